// File: rtl/bpa_pkg.sv
// Shared types, constants and helpers of the buddy page allocator.
package bpa_pkg;

    localparam int MIN_ORDER_LOG = 12;
    localparam int MAX_ORDER_LOG = 20;
    localparam int TOP_IDX       = MAX_ORDER_LOG - MIN_ORDER_LOG;
    localparam int NPAGES        = 1 << TOP_IDX;
    localparam int PAGE_W        = TOP_IDX;
    localparam int ORD_W         = 4;
    localparam int SIZE_W        = 21;
    localparam int ADDR_W        = MAX_ORDER_LOG;
    localparam int STAT_W        = 2;
    localparam int ENTRY_W       = ORD_W + 2;

    // Request kinds carried on tuser
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOBLOCK = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

    localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP_IDX);

    // One word per page
    typedef struct packed {
        logic [ORD_W-1:0] order;
        logic             in_use;
        logic             free;
    } t_entry;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_SCAN    = 6'b000010,
        S_SPLIT   = 6'b000100,
        S_FREE_RD = 6'b001000,
        S_MERGE   = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    // Smallest order index whose block holds the given byte count
    function automatic logic [ORD_W-1:0] order_for_size(input logic [SIZE_W-1:0] size);
        logic [ORD_W-1:0] res;
        res = TOP_ORD;
        for (int w = TOP_IDX; w >= 0; w--) begin
            if (size <= (SIZE_W'(1) << (w + MIN_ORDER_LOG))) begin
                res = ORD_W'(w);
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: rtl/buddy_page_allocator_core.sv
// Buddy page allocator: one request in, one status out per transaction.
// The allocator manages a 1 MiB arena of 256 pages of 4 KiB in a single page table
// memory (order, in-use, free-head per page) with registered read data. A free
// reads the page, takes one merge step per buddy (up to eight) and then commits.
// An allocate scans the whole table once to find the smallest free order that fits
// and its lowest block, then splits it down one order per step, claims the block
// and commits; an exhausted arena reports no block after the scan. A misaligned
// free or an oversized allocate goes straight to its result. One request is in
// work at a time and the next is taken in the cycle after the result is loaded; a
// finished result waits in the output register while the next request is accepted.
// No clearing pass is needed after reset.
module buddy_page_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,  // req_size[20:0], block_addr[40:21], zero pad
    input  logic        i_s_tuser,  // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata   // result_addr[19:0], status[21:20], zero pad
);

    localparam int PW = bpa_pkg::PAGE_W;
    localparam int OW = bpa_pkg::ORD_W;

    bpa_pkg::t_state r_state, n_state;
    logic [PW:0]     r_scan, n_scan;
    logic            r_rd_pend, n_rd_pend;
    logic [PW-1:0]   r_rd_addr;
    logic            r_rd_vbit;
    logic [OW-1:0]   r_want, n_want;
    logic [OW-1:0]   r_k, n_k;
    logic [PW-1:0]   r_p, n_p;
    logic            r_found, n_found;
    logic            r_fin_we, n_fin_we;
    logic [PW-1:0]   r_fin_addr, n_fin_addr;
    bpa_pkg::t_entry r_fin_data, n_fin_data;
    logic [bpa_pkg::ADDR_W-1:0] r_res_addr, n_res_addr;
    logic [bpa_pkg::STAT_W-1:0] r_res_st, n_res_st;
    logic            r_out_valid;
    logic [bpa_pkg::ADDR_W-1:0] r_out_addr;
    logic [bpa_pkg::STAT_W-1:0] r_out_st;
    logic [bpa_pkg::NPAGES-1:0] r_vld;

    logic            rd_en;
    logic [PW-1:0]   rd_addr;
    logic            we;
    logic [PW-1:0]   waddr;
    bpa_pkg::t_entry wdata;
    logic [bpa_pkg::ENTRY_W-1:0] ram_q;
    bpa_pkg::t_entry rd_ent;
    logic            out_load;

    logic [bpa_pkg::SIZE_W-1:0] in_size;
    logic [bpa_pkg::ADDR_W-1:0] in_addr;
    logic [PW-1:0]   buddy;
    logic [PW-1:0]   nbuddy;
    logic [OW-1:0]   kk;

    assign in_size = i_s_tdata[20:0];
    assign in_addr = i_s_tdata[40:21];

    bpa_ram #(.WIDTH(bpa_pkg::ENTRY_W), .DEPTH(bpa_pkg::NPAGES)) u_tab (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_addr),
        .o_rdata(ram_q)
    );

    // Never-written pages read as their reset value
    always_comb begin
        if (r_rd_vbit) begin
            rd_ent = bpa_pkg::t_entry'(ram_q);
        end else begin
            rd_ent.order  = bpa_pkg::TOP_ORD;
            rd_ent.in_use = 1'b0;
            rd_ent.free   = (r_rd_addr == '0);
        end
    end

    assign o_s_tready = (r_state == bpa_pkg::S_IDLE);
    assign out_load   = (r_state == bpa_pkg::S_DONE) && (!r_out_valid || i_m_tready);
    assign buddy      = r_p ^ (PW'(1) << r_k);

    // Sequencer: scan, split, merge
    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_want     = r_want;
        n_k        = r_k;
        n_p        = r_p;
        n_found    = r_found;
        n_fin_we   = r_fin_we;
        n_fin_addr = r_fin_addr;
        n_fin_data = r_fin_data;
        n_res_addr = r_res_addr;
        n_res_st   = r_res_st;
        n_rd_pend  = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = r_scan[PW-1:0];
        we         = 1'b0;
        waddr      = r_p;
        wdata      = r_fin_data;
        nbuddy     = '0;
        kk         = r_k;

        unique case (r_state)
            bpa_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_res_addr = '0;
                    n_res_st   = bpa_pkg::ST_OK;
                    n_fin_we   = 1'b0;
                    if (i_s_tuser == bpa_pkg::REQ_FREE) begin
                        if (in_addr[bpa_pkg::MIN_ORDER_LOG-1:0] != '0) begin
                            n_res_st = bpa_pkg::ST_BADFREE;
                            n_state  = bpa_pkg::S_DONE;
                        end else begin
                            rd_addr   = in_addr[bpa_pkg::ADDR_W-1:bpa_pkg::MIN_ORDER_LOG];
                            rd_en     = 1'b1;
                            n_p       = rd_addr;
                            n_state   = bpa_pkg::S_FREE_RD;
                        end
                    end else begin
                        if (in_size > (bpa_pkg::SIZE_W'(1) << bpa_pkg::MAX_ORDER_LOG)) begin
                            n_res_st = bpa_pkg::ST_NOBLOCK;
                            n_state  = bpa_pkg::S_DONE;
                        end else begin
                            n_want  = bpa_pkg::order_for_size(in_size);
                            n_found = 1'b0;
                            n_scan  = '0;
                            n_state = bpa_pkg::S_SCAN;
                        end
                    end
                end
            end
            bpa_pkg::S_SCAN: begin
                // Issue the next page read
                if (!r_scan[PW]) begin
                    rd_addr = r_scan[PW-1:0];
                    rd_en   = 1'b1;
                    n_scan  = r_scan + 1'b1;
                end
                // Keep the smallest fitting order, lowest page first
                if (r_rd_pend) begin
                    if (rd_ent.free && rd_ent.order >= r_want &&
                        (!r_found || rd_ent.order < r_k)) begin
                        n_found = 1'b1;
                        n_k     = rd_ent.order;
                        n_p     = r_rd_addr;
                    end
                    if (r_rd_addr == {PW{1'b1}}) begin
                        if (n_found) begin
                            n_state = bpa_pkg::S_SPLIT;
                        end else begin
                            n_res_st = bpa_pkg::ST_NOBLOCK;
                            n_state  = bpa_pkg::S_DONE;
                        end
                    end
                end
            end
            bpa_pkg::S_SPLIT: begin
                if (r_k > r_want) begin
                    // Free the right half one order down
                    kk           = r_k - 1'b1;
                    we           = 1'b1;
                    waddr        = r_p + (PW'(1) << kk);
                    wdata.order  = kk;
                    wdata.in_use = 1'b0;
                    wdata.free   = 1'b1;
                    n_k          = kk;
                end else begin
                    n_fin_we          = 1'b1;
                    n_fin_addr        = r_p;
                    n_fin_data.order  = r_want;
                    n_fin_data.in_use = 1'b1;
                    n_fin_data.free   = 1'b0;
                    n_res_addr        = {r_p, {bpa_pkg::MIN_ORDER_LOG{1'b0}}};
                    n_state           = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_FREE_RD: begin
                if (!rd_ent.in_use) begin
                    n_res_st = bpa_pkg::ST_BADFREE;
                    n_state  = bpa_pkg::S_DONE;
                end else begin
                    kk  = (rd_ent.order > bpa_pkg::TOP_ORD) ? bpa_pkg::TOP_ORD : rd_ent.order;
                    n_k = kk;
                    if (kk < bpa_pkg::TOP_ORD) begin
                        rd_addr = r_p ^ (PW'(1) << kk);
                        rd_en   = 1'b1;
                        n_state = bpa_pkg::S_MERGE;
                    end else begin
                        n_fin_we          = 1'b1;
                        n_fin_addr        = r_p;
                        n_fin_data.order  = kk;
                        n_fin_data.in_use = 1'b0;
                        n_fin_data.free   = 1'b1;
                        n_state           = bpa_pkg::S_DONE;
                    end
                end
            end
            bpa_pkg::S_MERGE: begin
                if (rd_ent.free && rd_ent.order == r_k) begin
                    // Retire the higher half, keep merging from the lower
                    we           = 1'b1;
                    waddr        = (buddy > r_p) ? buddy : r_p;
                    wdata.order  = r_k;
                    wdata.in_use = 1'b0;
                    wdata.free   = 1'b0;
                    n_p          = (buddy < r_p) ? buddy : r_p;
                    kk           = r_k + 1'b1;
                    n_k          = kk;
                    if (kk < bpa_pkg::TOP_ORD) begin
                        nbuddy  = n_p ^ (PW'(1) << kk);
                        rd_addr = nbuddy;
                        rd_en   = 1'b1;
                    end else begin
                        n_fin_we          = 1'b1;
                        n_fin_addr        = n_p;
                        n_fin_data.order  = kk;
                        n_fin_data.in_use = 1'b0;
                        n_fin_data.free   = 1'b1;
                        n_state           = bpa_pkg::S_DONE;
                    end
                end else begin
                    n_fin_we          = 1'b1;
                    n_fin_addr        = r_p;
                    n_fin_data.order  = r_k;
                    n_fin_data.in_use = 1'b0;
                    n_fin_data.free   = 1'b1;
                    n_state           = bpa_pkg::S_DONE;
                end
            end
            bpa_pkg::S_DONE: begin
                // Commit the head entry and hand over the result
                if (out_load) begin
                    we      = r_fin_we;
                    waddr   = r_fin_addr;
                    wdata   = r_fin_data;
                    n_state = bpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bpa_pkg::S_IDLE;
            end
        endcase
        n_rd_pend = rd_en;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpa_pkg::S_IDLE;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_fin_we    <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
            r_fin_we  <= n_fin_we;
            r_found   <= n_found;
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan     <= n_scan;
        r_want     <= n_want;
        r_k        <= n_k;
        r_p        <= n_p;
        r_fin_addr <= n_fin_addr;
        r_fin_data <= n_fin_data;
        r_res_addr <= n_res_addr;
        r_res_st   <= n_res_st;
        r_rd_addr  <= rd_addr;
        r_rd_vbit  <= r_vld[rd_addr];
        if (out_load) begin
            r_out_addr <= r_res_addr;
            r_out_st   <= r_res_st;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_st, r_out_addr};

    // Table writes only happen while a request is in work
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state != bpa_pkg::S_IDLE))
        else $error("page table written while idle");

    // A misaligned free is rejected at once
    a_badfree_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && i_s_tvalid && i_s_tuser == bpa_pkg::REQ_FREE &&
         in_addr[bpa_pkg::MIN_ORDER_LOG-1:0] != '0)
        |=> (r_state == bpa_pkg::S_DONE && r_res_st == bpa_pkg::ST_BADFREE))
        else $error("misaligned free not rejected");

    // Order index never leaves its range while splitting or merging
    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpa_pkg::S_SPLIT || r_state == bpa_pkg::S_MERGE)
        |-> (r_k <= bpa_pkg::TOP_ORD))
        else $error("order index out of range");

    // A merge step has its buddy read in flight, and the first step of a free its page read
    a_merge_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bpa_pkg::S_MERGE || r_state == bpa_pkg::S_FREE_RD) |-> r_rd_pend)
        else $error("merge step without table read");

endmodule

// File: sim/buddy_page_allocator_core_chk.sv
// Checker for the buddy page allocator: predicts each result and compares it.
module buddy_page_allocator_core_chk
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [47:0] i_s_tdata,  // req_size[20:0], block_addr[40:21], zero pad
    input  logic        i_s_tuser,  // req_type
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,  // result_addr[19:0], status[21:20], zero pad
    output int          o_fail_cnt,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [STAT_W-1:0] status;
    } t_result;

    logic [ORD_W-1:0] pg_order [NPAGES];
    logic             pg_used  [NPAGES];
    logic             pg_free  [NPAGES];
    t_result          pending_results [$];

    // Lowest page heading a free block of index k, NPAGES if none
    function automatic int find_free(int k);
        for (int p = 0; p < NPAGES; p++)
            if (pg_free[p] && pg_order[p] == k) return p;
        return NPAGES;
    endfunction

    // Apply one request to the page table and return its result
    function automatic t_result apply_request(logic kind, logic [SIZE_W-1:0] size,
                                              logic [ADDR_W-1:0] addr);
        t_result r;
        int      want, k, p, bud;
        r = '0;
        if (kind == REQ_ALLOC) begin
            if (size > (SIZE_W'(1) << MAX_ORDER_LOG)) begin
                r.status = ST_NOBLOCK;
                return r;
            end
            want = 0;
            while (want < TOP_IDX && (64'd1 << (want + MIN_ORDER_LOG)) < size) want++;
            p = NPAGES;
            for (k = want; k <= TOP_IDX; k++) begin
                p = find_free(k);
                if (p < NPAGES) break;
            end
            if (p >= NPAGES) begin
                r.status = ST_NOBLOCK;
                return r;
            end
            // Split down, freeing each right half
            while (k > want) begin
                k--;
                if (p + (1 << k) < NPAGES) begin
                    pg_free[p + (1 << k)]  = 1'b1;
                    pg_order[p + (1 << k)] = ORD_W'(k);
                end
            end
            pg_free[p]  = 1'b0;
            pg_used[p]  = 1'b1;
            pg_order[p] = ORD_W'(want);
            r.addr   = ADDR_W'(p << MIN_ORDER_LOG);
            r.status = ST_OK;
            return r;
        end
        p = int'(addr >> MIN_ORDER_LOG);
        if (addr[MIN_ORDER_LOG-1:0] != 0 || !pg_used[p]) begin
            r.status = ST_BADFREE;
            return r;
        end
        pg_used[p] = 1'b0;
        pg_free[p] = 1'b1;
        k = pg_order[p];
        if (k > TOP_IDX) k = TOP_IDX;
        pg_order[p] = ORD_W'(k);
        // Merge while the buddy is a free head of equal order
        while (k < TOP_IDX) begin
            bud = p ^ (1 << k);
            if (!pg_free[bud] || pg_order[bud] != k) break;
            pg_free[bud] = 1'b0;
            pg_free[p]   = 1'b0;
            if (bud < p) p = bud;
            k++;
            pg_free[p]  = 1'b1;
            pg_order[p] = ORD_W'(k);
        end
        r.status = ST_OK;
        return r;
    endfunction

    assign o_pending = pending_results.size();

    always @(posedge i_clk) begin
        t_result got, want_r;
        if (!i_rst_n) begin
            for (int p = 0; p < NPAGES; p++) begin
                pg_order[p] = TOP_ORD;
                pg_used[p]  = 1'b0;
                pg_free[p]  = (p == 0);
            end
            pending_results.delete();
            o_fail_cnt = 0;
        end else begin
            // Predict on each accepted request
            if (i_s_tvalid && i_s_tready)
                pending_results.push_back(apply_request(i_s_tuser, i_s_tdata[20:0],
                                                        i_s_tdata[40:21]));
            // Compare each accepted result with the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[19:0], i_m_tdata[21:20]};
                if (pending_results.size() == 0) begin
                    if (o_fail_cnt < 10)
                        $display("ERROR: unexpected result addr=%h status=%0d",
                                 got.addr, got.status);
                    o_fail_cnt++;
                end else begin
                    want_r = pending_results.pop_front();
                    if (got !== want_r || i_m_tdata[23:22] !== 2'b00) begin
                        if (o_fail_cnt < 10)
                            $display("ERROR: addr exp=%h got=%h, status exp=%0d got=%0d",
                                     want_r.addr, got.addr, want_r.status, got.status);
                        o_fail_cnt++;
                    end
                end
            end
        end
    end
endmodule

// File: sim/buddy_page_allocator_core_tb.sv
// Testbench top: drives requests into the allocator and gives the verdict.
module buddy_page_allocator_core_tb;
    import bpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, s_tuser;
    logic [47:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [23:0] m_tdata;
    int          fail_cnt, pending;
    int          hold_off;
    logic [ADDR_W-1:0] live_blocks [$];

    buddy_page_allocator_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata)
    );

    buddy_page_allocator_core_chk chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request and hold it until the transaction
    task automatic send_req(logic kind, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 48'($urandom);
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {7'd0, addr, size};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Drop the request and wait until every expected result has come
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending > 0) @(posedge clk);
    endtask

    task automatic alloc_req(logic [SIZE_W-1:0] size);
        send_req(REQ_ALLOC, size, ADDR_W'($urandom));
    endtask

    // Free a tracked block (most of the time) or a random address
    task automatic free_req(bit noisy);
        int idx;
        logic [ADDR_W-1:0] a;
        if (!noisy && live_blocks.size() > 0) begin
            idx = $urandom_range(0, live_blocks.size() - 1);
            a   = live_blocks[idx];
            live_blocks.delete(idx);
        end else begin
            a = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                            : ADDR_W'($urandom_range(0, 255) << 12);
        end
        send_req(REQ_FREE, SIZE_W'($urandom), a);
    endtask

    // Random allocate size, mostly small
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return SIZE_W'($urandom_range(0, 16384));
        if (r < 85) return SIZE_W'($urandom_range(0, 131072));
        if (r < 95) return SIZE_W'($urandom_range(0, 1048576));
        return SIZE_W'($urandom);
    endfunction

    // Track nonzero addresses of successful allocations from the result stream
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready && m_tdata[21:20] == ST_OK && m_tdata[19:0] != 0)
            live_blocks.push_back(m_tdata[19:0]);

    // Receiver stalls: random gaps plus one long hold-off on request
    initial begin
        int g;
        m_tready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_off > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0) begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin
        int wait_cnt;
        hold_off = 0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_ALLOC;
        s_tdata  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero size, whole arena, too large, bad frees, merges
        alloc_req(21'd0);
        alloc_req(21'd1048576);
        alloc_req(21'd1048577);
        alloc_req(21'h1FFFFF);
        send_req(REQ_FREE, '0, 20'h00000);
        send_req(REQ_FREE, '0, 20'h00001);
        send_req(REQ_FREE, '0, 20'hFFFFF);
        send_req(REQ_FREE, '0, 20'h00000);
        alloc_req(21'd1048576);
        send_req(REQ_FREE, '0, 20'h00000);
        alloc_req(21'd4096);
        alloc_req(21'd4097);
        alloc_req(21'd524288);
        send_req(REQ_FREE, '0, 20'h02000);
        send_req(REQ_FREE, '0, 20'h80000);
        send_req(REQ_FREE, '0, 20'h01000);
        send_req(REQ_FREE, '0, 20'h00000);
        send_req(REQ_FREE, '0, 20'hFF000);
        drain();
        live_blocks.delete();

        // Queue allocates while the receiver holds off
        hold_off = 1500;
        for (int i = 0; i < 6; i++) alloc_req(21'd4096);
        drain();

        // Random: mostly valid alloc/free pairs, some noise
        for (int i = 0; i < 1850; i++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 50) alloc_req(pick_size());
            else if (r < 90) free_req(1'b0);
            else free_req(1'b1);
            if (i == 900) drain();
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_cnt = 0;
        while (pending > 0 && wait_cnt < 20000) begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (300) @(posedge clk);
        if (fail_cnt == 0 && pending == 0)
            $display("buddy_page_allocator_core verification clean");
        else
            $display("buddy_page_allocator_core verification failed");
        $finish;
    end

    initial begin
        #50ms;
        $display("buddy_page_allocator_core verification failed");
        $finish;
    end
endmodule
